// ===== rtl/sumo_robot_attack_sequencer_core_macros.svh =====
// assertion helpers for the sequencer checks
`ifndef SUMO_ROBOT_ATTACK_SEQUENCER_CORE_MACROS_SVH
`define SUMO_ROBOT_ATTACK_SEQUENCER_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SRAS_AST_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sequencer port check failed");

// consequent checked in the cycle after the antecedent
`define SRAS_AST_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sequencer port check failed");

`endif

// ===== rtl/sras_pkg.sv =====
package sras_pkg;

  localparam int RANGE_BITS_DEF = 13;
  localparam int LINE_BITS_DEF  = 12;

  localparam int SENS_W = 11;
  localparam int THR_W  = 12;
  localparam int TICK_W = 8;
  localparam int SPD_W  = 7;
  localparam int PH_W   = 3;
  localparam int RET_W  = 2;
  localparam int DIR_W  = 2;

  // result word layout
  localparam int OUT_W      = 24;
  localparam int OUT_USED_W = 2 * SPD_W + 4 + PH_W;
  localparam int OUT_PH_LSB = 2 * SPD_W + 4;
  localparam int OUT_PWR_BIT = 2 * SPD_W + 3;

  // apb
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_SENSING  = 3'd0;
  localparam logic [2:0] REG_CONTACT  = 3'd1;
  localparam logic [2:0] REG_LINE_THR = 3'd2;
  localparam logic [2:0] REG_BACKUP   = 3'd3;
  localparam logic [2:0] REG_TURN     = 3'd4;
  localparam logic [2:0] REG_CRUISE   = 3'd5;
  localparam logic [2:0] REG_SPIN_REV = 3'd6;

  localparam logic [SENS_W-1:0] RST_SENSING  = 11'd400;
  localparam logic [SENS_W-1:0] RST_CONTACT  = 11'd150;
  localparam logic [THR_W-1:0]  RST_LINE_THR = 12'd3900;
  localparam logic [TICK_W-1:0] RST_BACKUP   = 8'd100;
  localparam logic [TICK_W-1:0] RST_TURN     = 8'd200;
  localparam logic [SPD_W-1:0]  RST_CRUISE   = 7'd60;

  // phase codes as seen on phase_now
  localparam logic [PH_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PH_W-1:0] PH_SEARCH = 3'd1;
  localparam logic [PH_W-1:0] PH_ATTACK = 3'd2;
  localparam logic [PH_W-1:0] PH_BACKUP = 3'd3;
  localparam logic [PH_W-1:0] PH_TURN   = 3'd4;

  localparam logic [RET_W-1:0] RET_SEARCH = 2'd1;
  localparam logic [RET_W-1:0] RET_ATTACK = 2'd2;

  // bit0 left reverse, bit1 right reverse
  localparam logic [DIR_W-1:0] DIR_FWD       = 2'b00;
  localparam logic [DIR_W-1:0] DIR_LEFT_REV  = 2'b01;
  localparam logic [DIR_W-1:0] DIR_RIGHT_REV = 2'b10;
  localparam logic [DIR_W-1:0] DIR_BOTH_REV  = 2'b11;

  localparam logic [SPD_W-1:0] SPD_FULL      = 7'd100;
  localparam logic [SPD_W-1:0] SPD_FOLLOW    = 7'd80;
  localparam logic [SPD_W-1:0] SPD_SPIN_FAST = 7'd70;
  localparam logic [SPD_W-1:0] SPD_SPIN_SLOW = 7'd10;
  localparam logic [SPD_W-1:0] K_FRONT       = 7'd80;
  localparam logic [SPD_W-1:0] K_SIDE        = 7'd40;

  // one quotient bit per divider step
  localparam int DIV_STEPS = SPD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [SENS_W-1:0] sensing;
    logic [SENS_W-1:0] contact;
    logic [THR_W-1:0]  line_thr;
    logic [TICK_W-1:0] backup;
    logic [TICK_W-1:0] turn;
    logic [SPD_W-1:0]  cruise;
    logic              spin_rev;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic div_step;
    logic div_last;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } sts_t;

  function automatic int in_width(int rb, int lb);
    return ((1 + 4 * (rb + 1) + 3 * lb + 7) / 8) * 8;
  endfunction

endpackage

// ===== rtl/sras_cfg.sv =====
module sras_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sras_pkg::ADDR_W-1:0] paddr,
  input  logic [sras_pkg::DATA_W-1:0] pwdata,
  output logic [sras_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output sras_pkg::cfg_t              cfg_o
);
  import sras_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensing  <= RST_SENSING;
      cfg_q.contact  <= RST_CONTACT;
      cfg_q.line_thr <= RST_LINE_THR;
      cfg_q.backup   <= RST_BACKUP;
      cfg_q.turn     <= RST_TURN;
      cfg_q.cruise   <= RST_CRUISE;
      cfg_q.spin_rev <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SENSING:  cfg_q.sensing  <= pwdata[SENS_W-1:0];
        REG_CONTACT:  cfg_q.contact  <= pwdata[SENS_W-1:0];
        REG_LINE_THR: cfg_q.line_thr <= pwdata[THR_W-1:0];
        REG_BACKUP:   cfg_q.backup   <= pwdata[TICK_W-1:0];
        REG_TURN:     cfg_q.turn     <= pwdata[TICK_W-1:0];
        REG_CRUISE:   cfg_q.cruise   <= pwdata[SPD_W-1:0];
        REG_SPIN_REV: cfg_q.spin_rev <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SENSING:  prdata = DATA_W'(cfg_q.sensing);
      REG_CONTACT:  prdata = DATA_W'(cfg_q.contact);
      REG_LINE_THR: prdata = DATA_W'(cfg_q.line_thr);
      REG_BACKUP:   prdata = DATA_W'(cfg_q.backup);
      REG_TURN:     prdata = DATA_W'(cfg_q.turn);
      REG_CRUISE:   prdata = DATA_W'(cfg_q.cruise);
      REG_SPIN_REV: prdata = DATA_W'(cfg_q.spin_rev);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== rtl/sras_ctrl.sv =====
module sras_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sras_pkg::sts_t sts_i,
  output sras_pkg::cmd_t cmd_o
);
  import sras_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } ctl_state_e;

  ctl_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        cnt_d      = '0;
        state_d    = sts_i.need_div ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          cmd_o.div_last = 1'b1;
          state_d        = ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        // wait for the output word slot
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/sras_dp.sv =====
module sras_dp #(
  parameter int  RANGE_BITS = sras_pkg::RANGE_BITS_DEF,
  parameter int  LINE_BITS  = sras_pkg::LINE_BITS_DEF,
  localparam int IN_W       = sras_pkg::in_width(RANGE_BITS, LINE_BITS)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sras_pkg::cfg_t             cfg_i,
  input  sras_pkg::cmd_t             cmd_i,
  output sras_pkg::sts_t             sts_o,
  input  logic [IN_W-1:0]            in_data_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [sras_pkg::OUT_W-1:0] out_data_o
);
  import sras_pkg::*;

  localparam int RW    = (RANGE_BITS > SENS_W) ? RANGE_BITS : SENS_W;
  localparam int LW    = (LINE_BITS > THR_W) ? LINE_BITS : THR_W;
  localparam int REM_W = RW + SPD_W;

  localparam int O_RSL  = 1;
  localparam int O_OKSL = O_RSL + RANGE_BITS;
  localparam int O_RFL  = O_OKSL + 1;
  localparam int O_OKFL = O_RFL + RANGE_BITS;
  localparam int O_RFR  = O_OKFL + 1;
  localparam int O_OKFR = O_RFR + RANGE_BITS;
  localparam int O_RSR  = O_OKFR + 1;
  localparam int O_OKSR = O_RSR + RANGE_BITS;
  localparam int O_LFL  = O_OKSR + 1;
  localparam int O_LFR  = O_LFL + LINE_BITS;
  localparam int O_LBK  = O_LFR + LINE_BITS;

  // captured tick
  logic                  start_q, oksl_q, okfl_q, okfr_q, oksr_q;
  logic [RANGE_BITS-1:0] rsl_q, rfl_q, rfr_q, rsr_q;
  logic [LINE_BITS-1:0]  lfl_q, lfr_q, lbk_q;

  // sequencer state
  logic [PH_W-1:0]   phase_q, phase_d;
  logic [RET_W-1:0]  ret_q, ret_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic              rse_q, rse_d;
  logic              rcp_q, rcp_d;
  logic [SPD_W-1:0]  hl_q, hl_d;
  logic [SPD_W-1:0]  hr_q, hr_d;
  logic [DIR_W-1:0]  dir_q, dir_d;
  logic              led_q, led_d;

  // divider
  logic [REM_W-1:0] rem_q, dsh_q, num;
  logic [SPD_W-1:0] quo_q, quo_nx;
  logic             dst_right_q, div_ge;

  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  logic [RW-1:0]    sens_x, cont_x, rsl_x, rfl_x, rfr_x, rsr_x;
  logic [LW-1:0]    thr_x;
  logic             lt_sl, lt_fl, lt_fr, lt_sr, gt_fl, gt_fr, ct_fl, ct_fr;
  logic             lh_fl, lh_fr, lh_bk;
  logic [SPD_W-1:0] cruise;

  logic             need_div, div_right, div_side;
  logic [RW-1:0]    div_range;
  logic [SPD_W-1:0] div_k;

  assign sens_x = RW'(cfg_i.sensing);
  assign cont_x = RW'(cfg_i.contact);
  assign rsl_x  = RW'(rsl_q);
  assign rfl_x  = RW'(rfl_q);
  assign rfr_x  = RW'(rfr_q);
  assign rsr_x  = RW'(rsr_q);
  assign thr_x  = LW'(cfg_i.line_thr);

  assign lt_sl = rsl_x < sens_x;
  assign lt_fl = rfl_x < sens_x;
  assign lt_fr = rfr_x < sens_x;
  assign lt_sr = rsr_x < sens_x;
  assign gt_fl = rfl_x > sens_x;
  assign gt_fr = rfr_x > sens_x;
  assign ct_fl = rfl_x < cont_x;
  assign ct_fr = rfr_x < cont_x;
  assign lh_fl = LW'(lfl_q) < thr_x;
  assign lh_fr = LW'(lfr_q) < thr_x;
  assign lh_bk = LW'(lbk_q) < thr_x;

  assign cruise = (cfg_i.cruise > SPD_FULL) ? SPD_FULL : cfg_i.cruise;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      start_q <= in_data_i[0];
      rsl_q   <= in_data_i[O_RSL +: RANGE_BITS];
      oksl_q  <= in_data_i[O_OKSL];
      rfl_q   <= in_data_i[O_RFL +: RANGE_BITS];
      okfl_q  <= in_data_i[O_OKFL];
      rfr_q   <= in_data_i[O_RFR +: RANGE_BITS];
      okfr_q  <= in_data_i[O_OKFR];
      rsr_q   <= in_data_i[O_RSR +: RANGE_BITS];
      oksr_q  <= in_data_i[O_OKSR];
      lfl_q   <= in_data_i[O_LFL +: LINE_BITS];
      lfr_q   <= in_data_i[O_LFR +: LINE_BITS];
      lbk_q   <= in_data_i[O_LBK +: LINE_BITS];
    end
  end

  // one tick of the fight sequence
  always_comb begin
    logic run_search, run_attack, check, bk_go, bk_side;
    logic fl, fr, ram;
    phase_d    = phase_q;
    ret_d      = ret_q;
    tick_d     = tick_q;
    rse_d      = rse_q;
    rcp_d      = rcp_q;
    hl_d       = hl_q;
    hr_d       = hr_q;
    dir_d      = dir_q;
    led_d      = led_q;
    need_div   = 1'b0;
    div_right  = 1'b0;
    div_side   = 1'b0;
    div_range  = '0;
    run_search = 1'b0;
    run_attack = 1'b0;
    check      = 1'b0;
    bk_go      = 1'b0;
    bk_side    = 1'b0;
    fl         = okfl_q && lt_fl;
    fr         = okfr_q && lt_fr;
    ram        = okfl_q && okfr_q && ct_fl && ct_fr;

    if (!start_q) begin
      if (phase_q != PH_IDLE) begin
        phase_d = PH_IDLE;
        hl_d    = '0;
        hr_d    = '0;
      end
    end else begin
      unique case (phase_q)
        PH_SEARCH: run_search = 1'b1;
        PH_ATTACK: run_attack = 1'b1;
        PH_BACKUP: begin
          if (lh_bk || tick_q >= cfg_i.backup) begin
            // escape side's wheel goes forward
            dir_d   = rse_q ? (dir_q & DIR_LEFT_REV) : (dir_q & DIR_RIGHT_REV);
            phase_d = PH_TURN;
            tick_d  = '0;
            if (rse_q) led_d = 1'b0;
          end else if (tick_q != '1) begin
            tick_d = tick_q + 1'b1;
          end
        end
        PH_TURN: begin
          if (rse_q) led_d = 1'b0;
          if (lt_fl || lt_fr || tick_q >= cfg_i.turn) begin
            rcp_d = 1'b0;
            if (rcp_q && lh_fr) begin
              bk_go   = 1'b1;
              bk_side = 1'b1;
            end else if (ret_q == RET_ATTACK) begin
              run_attack = 1'b1;
            end else begin
              run_search = 1'b1;
            end
          end else if (tick_q != '1) begin
            tick_d = tick_q + 1'b1;
          end
        end
        default: begin
          dir_d      = DIR_FWD;
          hl_d       = cfg_i.spin_rev ? SPD_SPIN_FAST : SPD_SPIN_SLOW;
          hr_d       = cfg_i.spin_rev ? SPD_SPIN_SLOW : SPD_SPIN_FAST;
          run_search = 1'b1;
        end
      endcase
    end

    if (run_search) begin
      if (gt_fl && gt_fr) begin
        phase_d = PH_SEARCH;
        ret_d   = RET_SEARCH;
        check   = 1'b1;
      end else begin
        run_attack = 1'b1;
      end
    end

    if (run_attack) begin
      phase_d = PH_ATTACK;
      ret_d   = RET_ATTACK;
      dir_d   = DIR_FWD;
      led_d   = 1'b1;
      check   = 1'b1;
      priority if (ram) begin
        hl_d  = SPD_FULL;
        hr_d  = SPD_FULL;
        check = fl && fr;
      end else if (fl) begin
        hr_d      = SPD_FOLLOW;
        need_div  = 1'b1;
        div_range = rfl_x;
      end else if (fr) begin
        hl_d      = SPD_FOLLOW;
        need_div  = 1'b1;
        div_right = 1'b1;
        div_range = rfr_x;
      end else if (oksl_q && lt_sl) begin
        dir_d     = DIR_LEFT_REV;
        hr_d      = SPD_FOLLOW;
        need_div  = 1'b1;
        div_side  = 1'b1;
        div_range = rsl_x;
      end else if (oksr_q && lt_sr) begin
        dir_d     = DIR_RIGHT_REV;
        hl_d      = SPD_FOLLOW;
        need_div  = 1'b1;
        div_right = 1'b1;
        div_side  = 1'b1;
        div_range = rsr_x;
      end else begin
        hl_d  = cruise;
        hr_d  = cruise;
        led_d = 1'b0;
      end
    end

    if (check) begin
      if (lh_fl) begin
        bk_go   = 1'b1;
        bk_side = 1'b0;
        rcp_d   = 1'b1;
      end else if (lh_fr) begin
        bk_go   = 1'b1;
        bk_side = 1'b1;
        rcp_d   = 1'b0;
      end
    end

    if (bk_go) begin
      dir_d    = DIR_BOTH_REV;
      hl_d     = cruise;
      hr_d     = cruise;
      phase_d  = PH_BACKUP;
      tick_d   = '0;
      rse_d    = bk_side;
      need_div = 1'b0;
    end
  end

  assign sts_o.need_div = need_div;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // range * k / sensing, quotient known to stay below k
  assign div_k  = div_side ? K_SIDE : K_FRONT;
  assign num    = REM_W'(div_range) * REM_W'(div_k);
  assign div_ge = rem_q >= dsh_q;
  assign quo_nx = {quo_q[SPD_W-2:0], div_ge};

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      rem_q       <= num;
      dsh_q       <= REM_W'(cfg_i.sensing) << (DIV_STEPS - 1);
      quo_q       <= '0;
      dst_right_q <= div_right;
    end else if (cmd_i.div_step) begin
      if (div_ge) rem_q <= rem_q - dsh_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= quo_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ret_q   <= RET_SEARCH;
      tick_q  <= '0;
      rse_q   <= 1'b0;
      rcp_q   <= 1'b0;
      hl_q    <= '0;
      hr_q    <= '0;
      dir_q   <= DIR_FWD;
      led_q   <= 1'b0;
    end else if (cmd_i.calc) begin
      phase_q <= phase_d;
      ret_q   <= ret_d;
      tick_q  <= tick_d;
      rse_q   <= rse_d;
      rcp_q   <= rcp_d;
      hl_q    <= hl_d;
      hr_q    <= hr_d;
      dir_q   <= dir_d;
      led_q   <= led_d;
    end else if (cmd_i.div_step && cmd_i.div_last) begin
      if (dst_right_q) hr_q <= quo_nx;
      else hl_q <= quo_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {(OUT_W - OUT_USED_W)'(0), phase_q, (phase_q != PH_IDLE), led_q,
                     dir_q[1], dir_q[0], hr_q, hl_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/sumo_robot_attack_sequencer_core.sv =====
// Mini-sumo fight sequencer. Each input word is one 1 ms tick carrying the start
// level, four range readings with their valid flags and three floor line readings;
// each tick yields exactly one output word with both wheel speeds and directions,
// the LED, the line-sensor power and the current phase (idle, search, attack,
// back-up, turn). Registers on the APB port (byte address 4*i): sensing distance,
// contact distance, line threshold, back-up ticks, turn ticks, cruise speed,
// spin reverse; write them only while no tick is in flight. An accepted tick goes
// through the calculation state, then the restoring divider (one quotient bit per
// cycle) if its attack speed follows a range reading, then the final state, which
// loads the output word once the output register is free. One tick is in flight at
// a time; the output register lets the next tick be taken while the previous word waits.
module sumo_robot_attack_sequencer_core #(
  parameter int  RANGE_BITS = sras_pkg::RANGE_BITS_DEF,
  parameter int  LINE_BITS  = sras_pkg::LINE_BITS_DEF,
  localparam int IN_W       = sras_pkg::in_width(RANGE_BITS, LINE_BITS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // start_signal, range_side_left, side_left_ok, range_front_left, front_left_ok,
  // range_front_right, front_right_ok, range_side_right, side_right_ok,
  // line_front_left, line_front_right, line_back, zero fill
  input  logic [IN_W-1:0]             s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // left_speed, right_speed, left_reverse, right_reverse, led_on, sensor_power,
  // phase_now, zero fill
  output logic [sras_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sras_pkg::ADDR_W-1:0] paddr,
  input  logic [sras_pkg::DATA_W-1:0] pwdata,
  output logic [sras_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import sras_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  sras_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sras_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sras_dp #(
    .RANGE_BITS (RANGE_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== rtl/sras_checker.sv =====
`include "sumo_robot_attack_sequencer_core_macros.svh"

module sras_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [sras_pkg::OUT_W-1:0] m_axis_tdata
);
  import sras_pkg::*;

  logic [SPD_W-1:0] ls, rs;
  logic [PH_W-1:0]  ph;
  logic             pwr;

  assign ls  = m_axis_tdata[SPD_W-1:0];
  assign rs  = m_axis_tdata[SPD_W +: SPD_W];
  assign pwr = m_axis_tdata[OUT_PWR_BIT];
  assign ph  = m_axis_tdata[OUT_PH_LSB +: PH_W];

  // line sensors powered exactly outside idle
  `SRAS_AST_SAME(a_power_phase, clk_i, rst_ni, m_axis_tvalid, pwr == (ph != PH_IDLE))
  // idle always shows stopped wheels
  `SRAS_AST_SAME(a_idle_stop, clk_i, rst_ni, m_axis_tvalid && ph == PH_IDLE, ls == '0 && rs == '0)
  `SRAS_AST_SAME(a_speed_max, clk_i, rst_ni, m_axis_tvalid, ls <= SPD_FULL && rs <= SPD_FULL)
  `SRAS_AST_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind sumo_robot_attack_sequencer_core sras_checker u_sras_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
